// ===== sv/two_level_page_table_engine_top_macros.svh =====
// Assertion helpers shared by the page table engine modules.
// Every check is sampled on the rising clock and is off while reset is high.
`ifndef TWO_LEVEL_PAGE_TABLE_ENGINE_TOP_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_ENGINE_TOP_MACROS_SVH

// The condition holds at every sampled edge.
`define TLPT_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define TLPT_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define TLPT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/tlpt_pkg.sv =====
package tlpt_pkg;

   localparam int TABLE_SLOTS   = 64;
   localparam int TABLE_ENTRIES = 1024;
   localparam int DIR_ENTRIES   = 1024;

   localparam int DIR_W       = $clog2(DIR_ENTRIES);
   localparam int IDX_W       = $clog2(TABLE_ENTRIES);
   localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int USED_W      = $clog2(TABLE_SLOTS + 1);
   localparam int LIMIT_W     = 7;
   localparam int CMP_W       = (USED_W > LIMIT_W) ? USED_W : LIMIT_W;
   localparam int STORE_DEPTH = TABLE_SLOTS * TABLE_ENTRIES;
   localparam int STORE_AW    = SLOT_W + IDX_W;
   localparam int FRAME_W     = 20;
   localparam int OFFSET_W    = 12;
   localparam int ADDR_W      = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] MODE_MAP     = 2'd0;
   localparam logic [1:0] MODE_UNMAP   = 2'd1;
   localparam logic [1:0] MODE_RESOLVE = 2'd2;

   typedef enum logic [1:0] {
      OP_MAP,
      OP_UNMAP,
      OP_RESOLVE,
      OP_NONE
   } op_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [ADDR_W-1:0] virt_addr;
      logic [ADDR_W-1:0] phys_addr;
      logic [1:0]        access_flags;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [ADDR_W-1:0] translated_addr;
      logic              hit;
      logic              invalidate;
   } rsp_type;

   // Request after decode, as it sits in the queue.
   typedef struct packed {
      op_type              op;
      logic [DIR_W-1:0]    dir_idx;
      logic [IDX_W-1:0]    tbl_idx;
      logic [OFFSET_W-1:0] offset;
      logic [FRAME_W-1:0]  frame;
      logic                flag_user;
      logic                flag_write;
   } cmd_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              user;
      logic              write;
      logic              present;
   } pde_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic               user;
      logic               write;
      logic               present;
   } pte_type;

endpackage

// ===== sv/tlpt_front.sv =====
module tlpt_front import tlpt_pkg::*; (
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_payload,
   input  logic     clearing,
   input  logic     q_full,
   output logic     q_push,
   output cmd_type  q_push_data
);

   op_type op;

   always_comb begin
      unique case (req_payload.mode)
         MODE_MAP:     op = OP_MAP;
         MODE_UNMAP:   op = OP_UNMAP;
         MODE_RESOLVE: op = OP_RESOLVE;
         default:      op = OP_NONE;
      endcase
   end

   // Nothing is taken while the tables are being cleared after reset.
   assign req_stall = clearing | q_full;
   assign q_push    = req_valid & ~req_stall;

   always_comb begin
      q_push_data.op         = op;
      q_push_data.dir_idx    = req_payload.virt_addr[ADDR_W-1 -: DIR_W];
      q_push_data.tbl_idx    = req_payload.virt_addr[OFFSET_W +: IDX_W];
      q_push_data.offset     = req_payload.virt_addr[OFFSET_W-1:0];
      q_push_data.frame      = req_payload.phys_addr[ADDR_W-1 -: FRAME_W];
      q_push_data.flag_write = req_payload.access_flags[0];
      q_push_data.flag_user  = req_payload.access_flags[1];
   end

endmodule

// ===== sv/tlpt_queue.sv =====
`include "two_level_page_table_engine_top_macros.svh"

module tlpt_queue import tlpt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    empty
);

   cmd_type              entry_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == Q_CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `TLPT_ASSERT_IMPLIES(a_push_has_room, push, count_ff != Q_CNT_W'(QUEUE_DEPTH), "push into full queue")
   `TLPT_ASSERT_IMPLIES(a_pop_has_data, pop, count_ff != '0, "pop from empty queue")

endmodule

// ===== sv/tlpt_back.sv =====
`include "two_level_page_table_engine_top_macros.svh"

module tlpt_back import tlpt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data,
   input  logic               q_empty,
   input  cmd_type            q_head,
   output logic               q_pop,
   output logic               clearing,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_payload
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_LOOK = 3'b100
   } back_state_type;

   back_state_type       state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [USED_W-1:0]    used_ff, used_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic                 clearing_ff, clearing_in;
   logic [STORE_AW-1:0]  clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   pde_type              dir_mem [DIR_ENTRIES];
   pte_type              st_mem [STORE_DEPTH];
   pde_type              dir_rd_ff;
   pte_type              st_rd_ff;

   logic                 dir_re, dir_we;
   logic [DIR_W-1:0]     dir_waddr;
   pde_type              dir_wdata;
   logic                 st_re, st_we;
   logic [STORE_AW-1:0]  st_raddr, st_waddr;
   pte_type              st_wdata;

   logic                 out_free;
   logic                 rsp_load;
   logic                 no_slot;
   logic                 alloc_fire;
   pde_type              map_pde;

   assign clearing    = clearing_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   // The slot count never passes TABLE_SLOTS, so reaching it means the pool is spent.
   assign no_slot = (CMP_W'(used_ff) >= CMP_W'(limit_ff)) ||
                    (used_ff == USED_W'(TABLE_SLOTS));

   always_comb begin
      map_pde = dir_rd_ff;
      if (dir_rd_ff.present) begin
         map_pde.write = dir_rd_ff.write | cmd_ff.flag_write;
         map_pde.user  = dir_rd_ff.user | cmd_ff.flag_user;
      end else begin
         map_pde.slot    = used_ff[SLOT_W-1:0];
         map_pde.user    = cmd_ff.flag_user;
         map_pde.write   = cmd_ff.flag_write;
         map_pde.present = 1'b1;
      end
   end

   always_comb begin
      limit_in = csr_wr_en ? csr_wr_data : limit_ff;

      clearing_in = clearing_ff;
      clr_in      = clr_ff;
      if (clearing_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == STORE_AW'(STORE_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      used_in    = used_ff;
      q_pop      = 1'b0;
      dir_re     = 1'b0;
      dir_we     = 1'b0;
      dir_waddr  = cmd_ff.dir_idx;
      dir_wdata  = map_pde;
      st_re      = 1'b0;
      st_raddr   = {dir_rd_ff.slot, cmd_ff.tbl_idx};
      st_we      = 1'b0;
      st_waddr   = {map_pde.slot, cmd_ff.tbl_idx};
      st_wdata   = '0;
      rsp_load   = 1'b0;
      rsp_in     = '0;
      alloc_fire = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (clearing_ff) begin
               st_we    = 1'b1;
               st_waddr = clr_ff;
               if (clr_ff < STORE_AW'(DIR_ENTRIES)) begin
                  dir_we    = 1'b1;
                  dir_waddr = clr_ff[DIR_W-1:0];
                  dir_wdata = '0;
               end
            end else if (!q_empty) begin
               q_pop    = 1'b1;
               dir_re   = 1'b1;
               cmd_in   = q_head;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            case (cmd_ff.op)
               OP_MAP: begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                     state_in = ST_IDLE;
                     if (!dir_rd_ff.present && no_slot) begin
                        rsp_in.status = 1'b1;
                     end else begin
                        dir_we           = 1'b1;
                        st_we            = 1'b1;
                        st_wdata.frame   = cmd_ff.frame;
                        st_wdata.user    = cmd_ff.flag_user;
                        st_wdata.write   = cmd_ff.flag_write;
                        st_wdata.present = 1'b1;
                        rsp_in.invalidate = 1'b1;
                        if (!dir_rd_ff.present) begin
                           used_in    = used_ff + 1'b1;
                           alloc_fire = 1'b1;
                        end
                     end
                  end
               end
               OP_UNMAP: begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                     state_in = ST_IDLE;
                     if (dir_rd_ff.present) begin
                        st_we             = 1'b1;
                        st_waddr          = {dir_rd_ff.slot, cmd_ff.tbl_idx};
                        rsp_in.invalidate = 1'b1;
                     end
                  end
               end
               OP_RESOLVE: begin
                  // The table entry is read even on an absent directory entry;
                  // the present bit gates the answer in ST_LOOK.
                  st_re    = 1'b1;
                  state_in = ST_LOOK;
               end
               default: begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end
         ST_LOOK: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               if (dir_rd_ff.present && st_rd_ff.present) begin
                  rsp_in.hit             = 1'b1;
                  rsp_in.translated_addr = {st_rd_ff.frame, cmd_ff.offset};
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         limit_ff     <= LIMIT_RESET;
         clearing_ff  <= 1'b1;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         limit_ff     <= limit_in;
         clearing_ff  <= clearing_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_mem[dir_waddr] <= dir_wdata;
      end
      if (dir_re) begin
         dir_rd_ff <= dir_mem[q_head.dir_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[st_waddr] <= st_wdata;
      end
      if (st_re) begin
         st_rd_ff <= st_mem[st_raddr];
      end
   end

   `TLPT_ASSERT_NEXT(a_alloc_step, alloc_fire, used_ff == $past(used_ff) + 1'b1, "slot count did not step by one")
   `TLPT_ASSERT_HOLDS(a_used_cap, used_ff <= USED_W'(TABLE_SLOTS), "slot count beyond pool size")
   `TLPT_ASSERT_IMPLIES(a_clear_quiet, clearing_ff, !q_pop && state_ff == ST_IDLE, "request taken during clear")

endmodule

// ===== sv/two_level_page_table_engine_top.sv =====
// Channel  Direction  Handshake              Payload
// req      in         req_valid, req_stall   req_type: mode, virt_addr, phys_addr, access_flags
// rsp      out        rsp_valid, rsp_stall   rsp_type: status, translated_addr, hit, invalidate
// csr      in         csr_wr_en              csr_wr_data: table_limit, 7 bits
//
// A request leaves the queue when the back end is idle and not clearing; its response is registered
// from ST_WALK for map, unmap and mode 3, and from ST_LOOK for resolve; the dependent directory
// read and table access set this order. A new request is taken only once the last is answered.
// After reset a clearing pass zeroes directory and table store, one entry a cycle, over
// TABLE_SLOTS * TABLE_ENTRIES entries (65536); req_stall is high for that time, csr writes go in.
// A stalled result is held in the output register; the queue keeps taking up to two requests.
module two_level_page_table_engine_top import tlpt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_payload,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

   logic     q_push;
   logic     q_full;
   cmd_type  q_push_data;
   cmd_type  q_head;
   logic     q_pop;
   logic     q_empty;
   logic     clearing;

   tlpt_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .clearing    (clearing),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   tlpt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   tlpt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_empty     (q_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .clearing    (clearing),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== dv/testbench.sv =====
module testbench import tlpt_pkg::*;;

   // Shadow of the page table: directory, table store and slot pool. Every accepted
   // request is walked here in order and the response it must produce is queued.
   class page_walk_scoreboard;
      pde_type            dir_shadow[DIR_ENTRIES];
      pte_type            store_shadow[STORE_DEPTH];
      int unsigned        slots_taken;
      logic [LIMIT_W-1:0] limit_shadow;
      rsp_type            expected_rsp[$];
      int unsigned        mismatches;

      function new();
         foreach (dir_shadow[i]) dir_shadow[i] = '0;
         foreach (store_shadow[i]) store_shadow[i] = '0;
         slots_taken  = 0;
         limit_shadow = LIMIT_RESET;
         mismatches   = 0;
      endfunction

      function void set_limit(logic [LIMIT_W-1:0] value);
         limit_shadow = value;
      endfunction

      function int outstanding();
         return expected_rsp.size();
      endfunction

      function void note_request(req_type r);
         rsp_type             want;
         pde_type             pde;
         pte_type             pte;
         logic [DIR_W-1:0]    d_idx;
         logic [IDX_W-1:0]    t_idx;
         int unsigned         usable;
         want  = '0;
         d_idx = r.virt_addr[31:22];
         t_idx = r.virt_addr[21:12];
         pde   = dir_shadow[d_idx];
         case (op_type'(r.mode))
            OP_MAP: begin
               if (!pde.present) begin
                  usable = (int'(limit_shadow) > TABLE_SLOTS) ? TABLE_SLOTS
                                                              : int'(limit_shadow);
                  if (slots_taken >= usable) begin
                     want.status = 1'b1;
                  end else begin
                     pde.slot    = slots_taken[SLOT_W-1:0];
                     pde.user    = r.access_flags[1];
                     pde.write   = r.access_flags[0];
                     pde.present = 1'b1;
                     slots_taken++;
                  end
               end else begin
                  // An existing directory entry only ever gains permissions.
                  pde.write = pde.write | r.access_flags[0];
                  pde.user  = pde.user | r.access_flags[1];
               end
               if (!want.status) begin
                  pte.frame   = r.phys_addr[31:12];
                  pte.user    = r.access_flags[1];
                  pte.write   = r.access_flags[0];
                  pte.present = 1'b1;
                  dir_shadow[d_idx] = pde;
                  store_shadow[{pde.slot, t_idx}] = pte;
                  want.invalidate = 1'b1;
               end
            end
            OP_UNMAP: begin
               if (pde.present) begin
                  store_shadow[{pde.slot, t_idx}] = '0;
                  want.invalidate = 1'b1;
               end
            end
            OP_RESOLVE: begin
               if (pde.present) begin
                  pte = store_shadow[{pde.slot, t_idx}];
                  if (pte.present) begin
                     want.translated_addr = {pte.frame, r.virt_addr[11:0]};
                     want.hit = 1'b1;
                  end
               end
            end
            default: ;
         endcase
         expected_rsp.push_back(want);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response with nothing outstanding: status=%0d addr=%h hit=%0d inv=%0d",
                        got.status, got.translated_addr, got.hit, got.invalidate);
            return;
         end
         want = expected_rsp.pop_front();
         if (got.status !== want.status || got.translated_addr !== want.translated_addr ||
             got.hit !== want.hit || got.invalidate !== want.invalidate) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"response mismatch: expected status=%0d addr=%h hit=%0d inv=%0d,",
                         " got status=%0d addr=%h hit=%0d inv=%0d"},
                        want.status, want.translated_addr, want.hit, want.invalidate,
                        got.status, got.translated_addr, got.hit, got.invalidate);
         end
      endfunction
   endclass

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   req_type            req_payload = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   rsp_type            rsp_payload;
   logic               csr_wr_en   = 1'b0;
   logic [LIMIT_W-1:0] csr_wr_data = '0;

   page_walk_scoreboard walk_sb;
   logic [DIR_W-1:0]    hot_dirs[12];
   logic [31:0]         recent_va[$];
   logic                calm = 1'b0;
   int                  stall_left = 0;
   int                  stall_len;
   int                  phase_limit[7] = '{127, 20, 64, 0, 0, 99, 64};

   two_level_page_table_engine_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mostly back to back, sometimes a few cycles, now and then a long pause.
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Most lookups and unmaps go to recently mapped pages so that they land on live
   // entries; maps favor a few hot directory slots so that permissions get promoted.
   function automatic req_type random_request();
      req_type     r;
      int          pick;
      logic [31:0] va;
      pick = $urandom_range(0, 99);
      r.mode = (pick < 38) ? OP_MAP : (pick < 56) ? OP_UNMAP : (pick < 95) ? OP_RESOLVE : OP_NONE;
      va = $urandom;
      if (r.mode != OP_NONE && recent_va.size() > 0 &&
          $urandom_range(0, 99) < ((r.mode == OP_MAP) ? 35 : 75)) begin
         va[31:12] = recent_va[$urandom_range(0, recent_va.size() - 1)][31:12];
      end else if ($urandom_range(0, 9) < 6) begin
         va[31:22] = hot_dirs[$urandom_range(0, 11)];
         if ($urandom_range(0, 1) == 0) va[21:12] = va[21:12] & 10'h007;
      end
      r.virt_addr    = va;
      r.phys_addr    = ($urandom_range(0, 19) == 0) ? 32'h0 : $urandom;
      r.access_flags = 2'($urandom_range(0, 3));
      if (r.mode == OP_MAP) begin
         recent_va.push_back(va);
         if (recent_va.size() > 24) void'(recent_va.pop_front());
      end
      return r;
   endfunction

   task automatic send_request(input req_type r);
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      walk_sb.note_request(r);
   endtask

   task automatic send_fields(input op_type op, input logic [31:0] va, input logic [31:0] pa,
                              input logic [1:0] flags);
      req_type r;
      r.mode         = op;
      r.virt_addr    = va;
      r.phys_addr    = pa;
      r.access_flags = flags;
      send_request(r);
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Let every outstanding transfer come back, plus a few cycles for the pipeline.
   task automatic drain();
      req_valid <= 1'b0;
      while (walk_sb.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      walk_sb.set_limit(value);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) walk_sb.check_response(rsp_payload);
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            stall_len = gap_len();
            rsp_stall  <= (stall_len > 0);
            stall_left <= (stall_len > 0) ? stall_len - 1 : 0;
         end
      end
   end

   initial begin
      walk_sb = new();
      hot_dirs[0]  = '0;
      hot_dirs[1]  = '1;
      for (int i = 2; i < 12; i++) hot_dirs[i] = DIR_W'($urandom);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // With no table slots allowed every map of a fresh directory entry fails.
      write_limit(7'd0);
      send_fields(OP_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b11);
      send_fields(OP_UNMAP, 32'h0, 32'h0, 2'b00);
      send_fields(OP_RESOLVE, 32'h0, 32'h0, 2'b00);
      send_fields(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b11);
      drain();

      write_limit(7'd2);
      send_fields(OP_MAP, 32'h0000_0000, 32'h0000_0000, 2'b00);
      send_fields(OP_RESOLVE, 32'h0000_0000, 32'h0, 2'b00);
      send_fields(OP_MAP, 32'h0000_1ABC, 32'hFFFF_FFFF, 2'b01);
      send_fields(OP_RESOLVE, 32'h0000_1FFF, 32'h0, 2'b00);
      send_fields(OP_MAP, 32'hFFC0_0000, 32'h1234_5000, 2'b10);
      send_fields(OP_MAP, 32'h0040_0000, 32'h0000_1000, 2'b11);
      send_fields(OP_MAP, 32'hFFFF_F000, 32'hABCD_E123, 2'b11);
      send_fields(OP_RESOLVE, 32'hFFFF_FFFF, 32'h0, 2'b00);
      send_fields(OP_UNMAP, 32'h0000_1000, 32'h0, 2'b00);
      send_fields(OP_RESOLVE, 32'h0000_1000, 32'h0, 2'b00);
      send_fields(OP_UNMAP, 32'h0000_1000, 32'h0, 2'b00);
      send_fields(OP_RESOLVE, 32'h0040_0000, 32'h0, 2'b00);
      send_fields(OP_NONE, 32'h0, 32'h0, 2'b00);
      drain();

      // A limit above the slot count behaves as the slot count.
      write_limit(7'd127);
      send_fields(OP_MAP, 32'h0040_0FFF, 32'h5555_5000, 2'b11);
      send_fields(OP_RESOLVE, 32'h0040_0ABC, 32'h0, 2'b00);

      for (int p = 0; p < 7; p++) begin
         drain();
         write_limit((p == 4) ? 7'($urandom_range(0, 127)) : 7'(phase_limit[p]));
         calm = (p == 2 || p == 5);
         for (int i = 0; i < 176; i++) begin
            send_request(random_request());
            if ($urandom_range(0, 149) == 0) drain();
            else if (!calm) hold_off(gap_len());
         end
      end

      req_valid <= 1'b0;
      while (walk_sb.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (walk_sb.mismatches == 0 && walk_sb.outstanding() == 0) begin
         $display("two_level_page_table_engine_top verification clean");
      end else begin
         $display("two_level_page_table_engine_top verification failed");
      end
      $finish;
   end

   // The clearing pass after reset alone zeroes all 65536 table store entries.
   initial begin
      #4000000;
      $display("two_level_page_table_engine_top verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/tlpt_pkg.sv
sv/tlpt_front.sv
sv/tlpt_queue.sv
sv/tlpt_back.sv
sv/two_level_page_table_engine_top.sv
dv/testbench.sv
